// File: rtl/bwt_pkg.sv
package bwt_pkg;

    localparam int ENTRIES_DEF = 16;

    // operation codes
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_FETCH  = 2'd2;
    localparam logic [1:0] OP_ACCESS = 2'd3;

    // entry kinds
    localparam logic KIND_BREAK = 1'b0;
    localparam logic KIND_WATCH = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // clears the byte offset of a data address
    localparam logic [31:0] WORD_MASK = 32'hFFFF_FFFC;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] address;
        logic        kind;
        logic [15:0] serial;
        logic [31:0] pc;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [15:0] hit_serial;
    } t_rsp;

    typedef struct packed {
        logic [31:0] address;
        logic        kind;
        logic [15:0] serial;
    } t_entry;

endpackage

// File: rtl/bwt_stream_if.sv
interface bwt_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/breakpoint_watchpoint_table.sv
// channel   dir  payload        notes
// i_req     in   bwt_pkg::t_req  op, address, kind, serial, pc; one word per item
// o_rsp     out  bwt_pkg::t_rsp  status, hit, hit_serial; one word per item
//
// each item is scanned at one entry read per cycle, then one step takes in the last read
// and the decide step writes its result word
// synchronous active-low reset empties the table (valid flags), zeroes the serial
// counter and both skip trackers; entry memory contents are not reset
// a result word waits in the output register while the next item is scanned;
// the decide step stalls only if that register is still full
module breakpoint_watchpoint_table #(
    parameter int ENTRIES = bwt_pkg::ENTRIES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bwt_stream_if.sink    i_req,
    bwt_stream_if.source  o_rsp
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state r_state;

    // item being worked on
    bwt_pkg::t_req r_req;
    logic [31:0]   r_key;      // pc for fetch, aligned address for access

    // scan control
    logic [CW-1:0] r_cnt;      // next entry to read
    logic          r_rd_act;   // a read returns this cycle
    logic [IW-1:0] r_ridx;     // entry of the returning read

    // scan results
    logic          r_found;
    logic [IW-1:0] r_fidx;
    logic [15:0]   r_fser;
    logic          r_free;
    logic [IW-1:0] r_free_idx;

    // table state
    logic [ENTRIES-1:0] r_valid;
    logic [15:0]        r_next_serial;
    logic [31:0]        r_last_break_pc;
    logic               r_break_skip;
    logic [31:0]        r_last_watch_pc;
    logic               r_watch_skip;

    // output register
    logic          r_out_vld;
    bwt_pkg::t_rsp r_out;

    // entry memory, one read port and one write port
    bwt_pkg::t_entry r_mem [ENTRIES];
    bwt_pkg::t_entry r_mem_q;

    logic            rd_en;
    logic [IW-1:0]   rd_addr;
    logic            ent_vld;
    logic            ent_match;
    logic            chk_kind;
    logic            is_check;
    logic            fin_go;
    logic [15:0]     n_serial;
    logic [31:0]     sel_last_pc;
    logic            sel_skip;
    logic            skip_now;
    logic            do_add;
    logic            do_del;
    logic            do_check;
    bwt_pkg::t_rsp   n_rsp;
    bwt_pkg::t_entry n_entry;

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;

    assign rd_en   = (r_state == S_SCAN) && (r_cnt < CW'(ENTRIES));
    assign rd_addr = r_cnt[IW-1:0];

    assign chk_kind = (r_req.op == bwt_pkg::OP_ACCESS) ? bwt_pkg::KIND_WATCH
                                                       : bwt_pkg::KIND_BREAK;
    assign is_check = (r_req.op == bwt_pkg::OP_FETCH) || (r_req.op == bwt_pkg::OP_ACCESS);

    // compare the entry coming out of memory against the item
    always_comb begin
        ent_vld = r_valid[r_ridx];
        unique case (r_req.op)
            bwt_pkg::OP_ADD:    ent_match = ent_vld && (r_mem_q.address == r_req.address);
            bwt_pkg::OP_DELETE: ent_match = ent_vld && (r_mem_q.serial == r_req.serial);
            default:            ent_match = ent_vld && (r_mem_q.kind == chk_kind)
                                            && (r_mem_q.address == r_key);
        endcase
    end

    // decide step: result word and write-back
    always_comb begin
        fin_go      = (r_state == S_FINISH) && (!r_out_vld || o_rsp.ready);
        n_serial    = r_next_serial + 16'd1;
        sel_last_pc = (r_req.op == bwt_pkg::OP_ACCESS) ? r_last_watch_pc : r_last_break_pc;
        sel_skip    = (r_req.op == bwt_pkg::OP_ACCESS) ? r_watch_skip : r_break_skip;
        skip_now    = (sel_last_pc == r_req.pc) && sel_skip;

        do_add   = (r_req.op == bwt_pkg::OP_ADD) && !r_found && r_free;
        do_del   = (r_req.op == bwt_pkg::OP_DELETE) && r_found;
        do_check = is_check && r_found;

        n_rsp.status     = bwt_pkg::ST_OK;
        n_rsp.hit        = 1'b0;
        n_rsp.hit_serial = '0;
        unique case (r_req.op)
            bwt_pkg::OP_ADD: begin
                if (!r_found) begin
                    if (r_free) begin
                        n_rsp.hit_serial = n_serial;
                    end else begin
                        n_rsp.status = bwt_pkg::ST_FULL;
                    end
                end
            end
            bwt_pkg::OP_DELETE: begin
                if (!r_found) begin
                    n_rsp.status = bwt_pkg::ST_NOT_FOUND;
                end
            end
            default: begin
                if (r_found && !skip_now) begin
                    n_rsp.hit        = 1'b1;
                    n_rsp.hit_serial = r_fser;
                end
            end
        endcase

        n_entry.address = r_req.address;
        n_entry.kind    = r_req.kind;
        n_entry.serial  = n_serial;
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (fin_go && do_add) begin
            r_mem[r_free_idx] <= n_entry;
        end
        if (rd_en) begin
            r_mem_q <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_out_vld       <= 1'b0;
            r_valid         <= '0;
            r_next_serial   <= '0;
            r_last_break_pc <= '0;
            r_break_skip    <= 1'b0;
            r_last_watch_pc <= '0;
            r_watch_skip    <= 1'b0;
            r_rd_act        <= 1'b0;
            r_cnt           <= '0;
            r_found         <= 1'b0;
            r_free          <= 1'b0;
        end else begin
            // a word leaving while the decide step refills the register stays valid
            if (o_rsp.valid && o_rsp.ready && !fin_go) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_req    <= i_req.data;
                        r_key    <= (i_req.data.op == bwt_pkg::OP_ACCESS)
                                    ? (i_req.data.address & bwt_pkg::WORD_MASK)
                                    : i_req.data.pc;
                        r_cnt    <= '0;
                        r_rd_act <= 1'b0;
                        r_found  <= 1'b0;
                        r_free   <= 1'b0;
                        r_state  <= S_SCAN;
                    end
                end

                S_SCAN: begin
                    r_rd_act <= rd_en;
                    r_ridx   <= rd_addr;
                    if (rd_en) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    // keep the lowest matching and the lowest free entry
                    if (r_rd_act) begin
                        if (ent_match && !r_found) begin
                            r_found <= 1'b1;
                            r_fidx  <= r_ridx;
                            r_fser  <= r_mem_q.serial;
                        end
                        if (!ent_vld && !r_free) begin
                            r_free     <= 1'b1;
                            r_free_idx <= r_ridx;
                        end
                    end
                    if (!rd_en) begin
                        r_state <= S_FINISH;
                    end
                end

                S_FINISH: begin
                    if (fin_go) begin
                        r_out     <= n_rsp;
                        r_out_vld <= 1'b1;
                        r_state   <= S_IDLE;
                        if (do_add) begin
                            r_valid[r_free_idx] <= 1'b1;
                            r_next_serial       <= n_serial;
                        end
                        if (do_del) begin
                            r_valid[r_fidx] <= 1'b0;
                        end
                        // alternate hit and skip at a repeated pc
                        if (do_check) begin
                            if (r_req.op == bwt_pkg::OP_ACCESS) begin
                                if (skip_now) begin
                                    r_watch_skip <= 1'b0;
                                end else begin
                                    r_last_watch_pc <= r_req.pc;
                                    r_watch_skip    <= 1'b1;
                                end
                            end else begin
                                if (skip_now) begin
                                    r_break_skip <= 1'b0;
                                end else begin
                                    r_last_break_pc <= r_req.pc;
                                    r_break_skip    <= 1'b1;
                                end
                            end
                        end
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/bwt_checker.sv
module bwt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [1:0]  i_rsp_status,
    input logic        i_rsp_hit,
    input logic [15:0] i_rsp_hit_serial
);

    // result word holds while stalled
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status)
            && $stable(i_rsp_hit) && $stable(i_rsp_hit_serial))
        else $error("result word changed while stalled");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while an item is in flight");

    // a hit is only reported with ok status
    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_hit |-> i_rsp_status == bwt_pkg::ST_OK)
        else $error("hit reported with error status");

    // error results carry no serial
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status == bwt_pkg::ST_FULL
            || i_rsp_status == bwt_pkg::ST_NOT_FOUND) |-> !i_rsp_hit && i_rsp_hit_serial == '0)
        else $error("error result with hit or serial");

endmodule

bind breakpoint_watchpoint_table bwt_checker u_bwt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_status     (o_rsp.data.status),
    .i_rsp_hit        (o_rsp.data.hit),
    .i_rsp_hit_serial (o_rsp.data.hit_serial)
);

// File: verif/tb_breakpoint_watchpoint_table.sv
`timescale 1ns / 1ps

module tb_breakpoint_watchpoint_table;

    localparam int ENTRIES     = bwt_pkg::ENTRIES_DEF;
    localparam int PHASES      = 9;
    localparam int PHASE_WORDS = 95;
    localparam int ADDR_POOL   = 24;
    localparam int PC_POOL     = 8;
    // worst case per word: idle gap, scan and output stall, with a wide margin
    localparam int CYCLE_LIMIT = 400_000;
    localparam int DRAIN_CYCLES = 2 * ENTRIES + 8;

    // traffic mixes for the random phases
    localparam int MIX_BALANCED = 0;
    localparam int MIX_FILL     = 1;
    localparam int MIX_DRAIN    = 2;

    typedef struct {
        bwt_pkg::t_req word;
        bit            typed;
        bwt_pkg::t_rsp rsp;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    bwt_stream_if #(.t_payload(bwt_pkg::t_req)) req_if ();
    bwt_stream_if #(.t_payload(bwt_pkg::t_rsp)) rsp_if ();

    breakpoint_watchpoint_table #(
        .ENTRIES (ENTRIES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // shadow copy of the table and the two skip trackers
    bit              tbl_valid [ENTRIES];
    bwt_pkg::t_entry tbl_entry [ENTRIES];
    logic [15:0]     serial_ctr;
    logic [31:0]     brk_last_pc;
    bit              brk_skip;
    logic [31:0]     wch_last_pc;
    bit              wch_skip;

    // result words still owed by the block, oldest first
    bwt_pkg::t_rsp rsp_pending [$];
    t_row          dir_rows [$];

    logic [31:0] addr_pool [ADDR_POOL];
    logic [31:0] pc_pool [PC_POOL];

    bit allow_idle;
    int fail_count;
    int cycle_count;

    // coverage tallies for the closing summary
    int n_words;
    int n_new;
    int n_full;
    int n_absent;
    int n_hit;
    int n_skip;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void table_reset();
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_entry[i] = '0;
        end
        serial_ctr  = '0;
        brk_last_pc = '0;
        brk_skip    = 1'b0;
        wch_last_pc = '0;
        wch_skip    = 1'b0;
    endfunction

    // applies one word to the shadow table and returns the result word it causes
    function automatic bwt_pkg::t_rsp table_step(input bwt_pkg::t_req w);
        bwt_pkg::t_rsp r;
        int            free_slot;
        int            hit_slot;
        bit            present;
        logic [31:0]   key;
        logic          want_kind;
        r         = '0;
        free_slot = -1;
        hit_slot  = -1;
        present   = 1'b0;
        n_words++;
        case (w.op)
            bwt_pkg::OP_ADD: begin
                // an address already present blocks the add, whatever its kind
                for (int i = 0; i < ENTRIES; i++) begin
                    if (tbl_valid[i]) begin
                        if (tbl_entry[i].address == w.address) present = 1'b1;
                    end else if (free_slot < 0) begin
                        free_slot = i;
                    end
                end
                if (!present) begin
                    if (free_slot < 0) begin
                        r.status = bwt_pkg::ST_FULL;
                        n_full++;
                    end else begin
                        serial_ctr                  = serial_ctr + 16'd1;
                        tbl_valid[free_slot]        = 1'b1;
                        tbl_entry[free_slot].address = w.address;
                        tbl_entry[free_slot].kind    = w.kind;
                        tbl_entry[free_slot].serial  = serial_ctr;
                        r.hit_serial                = serial_ctr;
                        n_new++;
                    end
                end
            end
            bwt_pkg::OP_DELETE: begin
                r.status = bwt_pkg::ST_NOT_FOUND;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (tbl_valid[i] && tbl_entry[i].serial == w.serial) begin
                        tbl_valid[i] = 1'b0;
                        r.status     = bwt_pkg::ST_OK;
                        break;
                    end
                end
                if (r.status == bwt_pkg::ST_NOT_FOUND) n_absent++;
            end
            default: begin
                // fetch matches breakpoints at the pc, access matches
                // watchpoints at the word-aligned data address
                if (w.op == bwt_pkg::OP_FETCH) begin
                    key       = w.pc;
                    want_kind = bwt_pkg::KIND_BREAK;
                end else begin
                    key       = w.address & bwt_pkg::WORD_MASK;
                    want_kind = bwt_pkg::KIND_WATCH;
                end
                for (int i = 0; i < ENTRIES; i++) begin
                    if (hit_slot < 0 && tbl_valid[i] && tbl_entry[i].kind == want_kind
                            && tbl_entry[i].address == key)
                        hit_slot = i;
                end
                if (hit_slot >= 0) begin
                    // a repeat at the last hit pc is swallowed once
                    if (w.op == bwt_pkg::OP_FETCH) begin
                        if (brk_skip && brk_last_pc == w.pc) begin
                            brk_skip = 1'b0;
                        end else begin
                            brk_last_pc = w.pc;
                            brk_skip    = 1'b1;
                            r.hit       = 1'b1;
                        end
                    end else begin
                        if (wch_skip && wch_last_pc == w.pc) begin
                            wch_skip = 1'b0;
                        end else begin
                            wch_last_pc = w.pc;
                            wch_skip    = 1'b1;
                            r.hit       = 1'b1;
                        end
                    end
                    if (r.hit) begin
                        r.hit_serial = tbl_entry[hit_slot].serial;
                        n_hit++;
                    end else begin
                        n_skip++;
                    end
                end
            end
        endcase
        return r;
    endfunction

    // picks a live entry, of one kind or of any kind when want_kind is negative
    function automatic bit live_entry(input int want_kind, output bwt_pkg::t_entry e);
        int idx [$];
        e = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i] && (want_kind < 0 || int'(tbl_entry[i].kind) == want_kind))
                idx.push_back(i);
        end
        if (idx.size() == 0) return 1'b0;
        e = tbl_entry[idx[$urandom_range(0, idx.size() - 1)]];
        return 1'b1;
    endfunction

    // mostly a small pool so adds collide and the table fills up
    function automatic logic [31:0] pick_addr();
        if ($urandom_range(0, 9) < 7) return addr_pool[$urandom_range(0, ADDR_POOL - 1)];
        return $urandom;
    endfunction

    // builds one random word; most aim at live entries, some are plain noise
    function automatic bwt_pkg::t_req make_word(input int mix);
        bwt_pkg::t_req   w;
        bwt_pkg::t_entry e;
        int              roll;
        int              add_pct;
        int              del_pct;
        w.op      = 2'($urandom_range(0, 3));
        w.address = $urandom;
        w.kind    = 1'($urandom_range(0, 1));
        w.serial  = 16'($urandom_range(0, 65535));
        w.pc      = $urandom;
        if ($urandom_range(0, 99) < 12) return w;
        case (mix)
            MIX_FILL: begin
                add_pct = 55;
                del_pct = 10;
            end
            MIX_DRAIN: begin
                add_pct = 10;
                del_pct = 50;
            end
            default: begin
                add_pct = 25;
                del_pct = 25;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < add_pct) w.op = bwt_pkg::OP_ADD;
        else if (roll < add_pct + del_pct) w.op = bwt_pkg::OP_DELETE;
        else if (roll < add_pct + del_pct + (100 - add_pct - del_pct) / 2)
            w.op = bwt_pkg::OP_FETCH;
        else w.op = bwt_pkg::OP_ACCESS;
        case (w.op)
            bwt_pkg::OP_ADD: begin
                w.address = pick_addr();
            end
            bwt_pkg::OP_DELETE: begin
                // live serial, the next one to be handed out, which is absent, or a random one
                if ($urandom_range(0, 4) != 0 && live_entry(-1, e)) w.serial = e.serial;
                else if ($urandom_range(0, 1) == 1) w.serial = serial_ctr + 16'd1;
            end
            bwt_pkg::OP_FETCH: begin
                if ($urandom_range(0, 2) == 0) w.pc = brk_last_pc;
                else if ($urandom_range(0, 4) != 0
                         && live_entry(int'(bwt_pkg::KIND_BREAK), e))
                    w.pc = e.address;
                else w.pc = pick_addr();
            end
            default: begin
                // any byte offset within the watched word
                if ($urandom_range(0, 4) != 0 && live_entry(int'(bwt_pkg::KIND_WATCH), e))
                    w.address = e.address | 32'($urandom_range(0, 3));
                else w.address = pick_addr();
                w.pc = ($urandom_range(0, 2) == 0) ? wch_last_pc
                                                   : pc_pool[$urandom_range(0, PC_POOL - 1)];
            end
        endcase
        return w;
    endfunction

    function automatic int mix_of(input int phase);
        case (phase % 4)
            1, 2:    return MIX_FILL;
            3:       return MIX_DRAIN;
            default: return MIX_BALANCED;
        endcase
    endfunction

    task automatic dir_row(input logic [1:0] op, input logic [31:0] address, input logic kind,
                           input logic [15:0] serial, input logic [31:0] pc);
        t_row row;
        row.word  = '{op, address, kind, serial, pc};
        row.typed = 1'b0;
        row.rsp   = '0;
        dir_rows.push_back(row);
    endtask

    // row whose result word is obvious from the table contents at that point
    task automatic dir_typed(input logic [1:0] op, input logic [31:0] address, input logic kind,
                             input logic [15:0] serial, input logic [31:0] pc,
                             input logic [1:0] status, input logic [15:0] hit_serial);
        t_row row;
        row.word  = '{op, address, kind, serial, pc};
        row.typed = 1'b1;
        row.rsp   = '{status, 1'b0, hit_serial};
        dir_rows.push_back(row);
    endtask

    // drives one word, waits for the handshake, then books its result
    task automatic send_word(input bwt_pkg::t_req w, input bit typed,
                             input bwt_pkg::t_rsp typed_rsp);
        bwt_pkg::t_rsp model_rsp;
        if (allow_idle && $urandom_range(0, 5) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= w;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        model_rsp = table_step(w);
        rsp_pending.push_back(typed ? typed_rsp : model_rsp);
    endtask

    // result side: random stall bursts and field-by-field comparison
    initial begin
        bwt_pkg::t_rsp exp_rsp;
        int            stall_left;
        stall_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
                if (rsp_pending.size() == 0) begin
                    $error("unexpected result word: status %0d hit %0d hit_serial %0d",
                           rsp_if.data.status, rsp_if.data.hit, rsp_if.data.hit_serial);
                    fail_count++;
                end else begin
                    exp_rsp = rsp_pending.pop_front();
                    if (rsp_if.data.status !== exp_rsp.status) begin
                        $error("status: expected %0d, got %0d",
                               exp_rsp.status, rsp_if.data.status);
                        fail_count++;
                    end
                    if (rsp_if.data.hit !== exp_rsp.hit) begin
                        $error("hit: expected %0d, got %0d", exp_rsp.hit, rsp_if.data.hit);
                        fail_count++;
                    end
                    if (rsp_if.data.hit_serial !== exp_rsp.hit_serial) begin
                        $error("hit_serial: expected %0d, got %0d",
                               exp_rsp.hit_serial, rsp_if.data.hit_serial);
                        fail_count++;
                    end
                end
            end
            if (allow_idle && stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if (allow_idle && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(0, 17);
                rsp_if.ready <= 1'b0;
            end else begin
                stall_left = 0;
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[breakpoint_watchpoint_table] ERROR");
        $finish;
    end

    initial begin
        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        allow_idle   = 1'b0;
        fail_count   = 0;
        n_words      = 0;
        n_new        = 0;
        n_full       = 0;
        n_absent     = 0;
        n_hit        = 0;
        n_skip       = 0;
        table_reset();

        // address pool: extremes, then a mix of aligned and unaligned values
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        addr_pool[2] = bwt_pkg::WORD_MASK;
        addr_pool[3] = 32'h8000_0000;
        for (int i = 4; i < ADDR_POOL; i++)
            addr_pool[i] = (i % 2 == 0) ? ($urandom & bwt_pkg::WORD_MASK) : $urandom;
        pc_pool[0] = '0;
        pc_pool[1] = '1;
        for (int i = 2; i < PC_POOL; i++) pc_pool[i] = $urandom;

        // empty table: checks miss, deletes find nothing
        dir_typed(bwt_pkg::OP_FETCH,  0,  bwt_pkg::KIND_BREAK, 0,  0,  bwt_pkg::ST_OK, 0);
        dir_typed(bwt_pkg::OP_ACCESS, 0,  bwt_pkg::KIND_BREAK, 0,  0,  bwt_pkg::ST_OK, 0);
        dir_typed(bwt_pkg::OP_DELETE, 0,  bwt_pkg::KIND_BREAK, 0,  0,
                  bwt_pkg::ST_NOT_FOUND, 0);
        dir_typed(bwt_pkg::OP_DELETE, '1, bwt_pkg::KIND_WATCH, '1, '1,
                  bwt_pkg::ST_NOT_FOUND, 0);
        // first serials, then a duplicate address of the other kind is ignored
        dir_typed(bwt_pkg::OP_ADD, 0,  bwt_pkg::KIND_BREAK, 0, 0, bwt_pkg::ST_OK, 16'd1);
        dir_typed(bwt_pkg::OP_ADD, '1, bwt_pkg::KIND_WATCH, 0, 0, bwt_pkg::ST_OK, 16'd2);
        dir_typed(bwt_pkg::OP_ADD, 0,  bwt_pkg::KIND_WATCH, 0, 0, bwt_pkg::ST_OK, 0);
        // breakpoint repeats at one pc: hit, skip, hit
        dir_row(bwt_pkg::OP_FETCH, 0, bwt_pkg::KIND_BREAK, 0, 0);
        dir_row(bwt_pkg::OP_FETCH, 0, bwt_pkg::KIND_BREAK, 0, 0);
        dir_row(bwt_pkg::OP_FETCH, 0, bwt_pkg::KIND_BREAK, 0, 0);
        // unaligned watchpoint entry never matches an aligned access
        dir_typed(bwt_pkg::OP_ACCESS, '1, bwt_pkg::KIND_BREAK, 0, '1, bwt_pkg::ST_OK, 0);
        dir_row(bwt_pkg::OP_ADD,    bwt_pkg::WORD_MASK, bwt_pkg::KIND_WATCH, 0, 0);
        // watch repeats, byte offset ignored, then a new pc hits again
        dir_row(bwt_pkg::OP_ACCESS, '1,                 bwt_pkg::KIND_BREAK, 0, '1);
        dir_row(bwt_pkg::OP_ACCESS, 32'hFFFF_FFFD,      bwt_pkg::KIND_BREAK, 0, '1);
        dir_row(bwt_pkg::OP_ACCESS, bwt_pkg::WORD_MASK, bwt_pkg::KIND_BREAK, 0, 0);
        // fetch does not match a watchpoint at the same address
        dir_row(bwt_pkg::OP_FETCH,  0, bwt_pkg::KIND_BREAK, 0, bwt_pkg::WORD_MASK);
        dir_row(bwt_pkg::OP_DELETE, 0, bwt_pkg::KIND_BREAK, 16'd1, 0);
        dir_row(bwt_pkg::OP_FETCH,  0, bwt_pkg::KIND_BREAK, 0, 0);
        dir_typed(bwt_pkg::OP_DELETE, 0, bwt_pkg::KIND_BREAK, 16'd1, 0,
                  bwt_pkg::ST_NOT_FOUND, 0);
        // unused fields at their extremes, freed slot reused
        dir_row(bwt_pkg::OP_ADD,    32'h8000_0000, bwt_pkg::KIND_BREAK, '1, '1);
        dir_row(bwt_pkg::OP_FETCH,  '1,            bwt_pkg::KIND_WATCH, '1, 32'h8000_0000);
        dir_row(bwt_pkg::OP_DELETE, '1,            bwt_pkg::KIND_WATCH, 16'd4, '1);
        dir_row(bwt_pkg::OP_ACCESS, 0,             bwt_pkg::KIND_WATCH, '1, 0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        allow_idle = 1'b1;
        foreach (dir_rows[k]) send_word(dir_rows[k].word, dir_rows[k].typed, dir_rows[k].rsp);

        // random phases: fill to overflow, drain, mixed traffic
        for (int phase = 0; phase < PHASES; phase++) begin
            allow_idle = (phase != PHASES - 1) && (phase % 3 != 2);
            repeat (PHASE_WORDS) send_word(make_word(mix_of(phase)), 1'b0, '0);
            // hold the sender until every owed word is back
            req_if.valid <= 1'b0;
            do @(posedge i_clk); while (rsp_pending.size() != 0);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d words: %0d new entries, %0d adds to a full table",
                 n_words, n_new, n_full);
        $display("%0d absent deletes; checks reported %0d hits and skipped %0d repeats",
                 n_absent, n_hit, n_skip);
        if (fail_count == 0 && rsp_pending.size() == 0) begin
            $display("[breakpoint_watchpoint_table] OK");
        end else begin
            $display("[breakpoint_watchpoint_table] ERROR");
        end
        $finish;
    end

endmodule
